[hw/rtl/tspu_pkg.sv]
// ----------------------------------------------------------------------------
// tspu_pkg: shared constants and types for the phase unwrap pixel pipeline
// cordic arctangent table, widths, stage payload types
// ----------------------------------------------------------------------------
`default_nettype none

package tspu_pkg;

  localparam int GrayBits   = 7;
  localparam int PhaseBits  = 16;
  localparam int PixelBits  = 8;
  localparam int CordicSteps = 30;
  localparam int UnwrapBits = 24;

  // vectoring datapath width: |x|,|y| grow below 2^31 * 1.65 * 1.65
  localparam int VecW = 34;
  // rotation datapath width: magnitude below 2^30 * 1.65
  localparam int RotW = 33;
  localparam int SumW = RotW + 1;

  localparam logic signed [15:0] Sqrt3Q14 = 16'sd28378;

  typedef logic [31:0] ang_t;

  function automatic ang_t atan_tab(input int i);
    ang_t t;
    unique case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2F9;
      15: t = 32'h0000517C;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A2F;
      19: t = 32'h00000517;
      20: t = 32'h0000028B;
      21: t = 32'h00000145;
      22: t = 32'h000000A2;
      23: t = 32'h00000051;
      24: t = 32'h00000028;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000002;
      29: t = 32'h00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

  // side data that rides along with every pixel
  typedef struct packed {
    logic [GrayBits-1:0] order;
    logic                frame_end;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/tspu_vec_cordic.sv]
// ----------------------------------------------------------------------------
// tspu_vec_cordic: pipelined cordic vectoring, angle of (x, y)
// one iteration per register stage, zero vector gives angle zero
// ----------------------------------------------------------------------------
`default_nettype none

module tspu_vec_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic signed [tspu_pkg::VecW-1:0]    in_x,
  input  wire logic signed [tspu_pkg::VecW-1:0]    in_y,
  input  wire tspu_pkg::side_t                     in_side,
  output logic                                     out_valid,
  output tspu_pkg::ang_t                           out_ang,
  output tspu_pkg::side_t                          out_side
);

  localparam int N = tspu_pkg::CordicSteps;
  localparam int W = tspu_pkg::VecW;

  logic                valid_r [N+1];
  logic signed [W-1:0] x_r     [N+1];
  logic signed [W-1:0] y_r     [N+1];
  tspu_pkg::ang_t      a_r     [N+1];
  logic                zero_r  [N+1];
  tspu_pkg::side_t     side_r  [N+1];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    side_r[0] <= in_side;
    if (in_x < 0) begin
      x_r[0] <= -in_x;
      y_r[0] <= -in_y;
      a_r[0] <= 32'h80000000;
    end else begin
      x_r[0] <= in_x;
      y_r[0] <= in_y;
      a_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else begin
        valid_r[i+1] <= valid_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      side_r[i+1] <= side_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + tspu_pkg::atan_tab(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - tspu_pkg::atan_tab(i);
      end
    end
  end

  assign out_valid = valid_r[N];
  assign out_ang   = zero_r[N] ? '0 : a_r[N];
  assign out_side  = side_r[N];

endmodule

`default_nettype wire

[hw/rtl/tspu_rot_cordic.sv]
// ----------------------------------------------------------------------------
// tspu_rot_cordic: pipelined cordic rotation, unscaled vector of an angle
// one iteration per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module tspu_rot_cordic (
  input  wire logic                               clk,
  input  wire tspu_pkg::ang_t                     in_ang,
  output logic signed [tspu_pkg::RotW-1:0]        out_x,
  output logic signed [tspu_pkg::RotW-1:0]        out_y
);

  localparam int N = tspu_pkg::CordicSteps;
  localparam int W = tspu_pkg::RotW;

  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  tspu_pkg::ang_t      z_r [N+1];

  // left half plane starts from the negative x axis
  always_ff @(posedge clk) begin
    y_r[0] <= '0;
    if (in_ang[31] ^ in_ang[30]) begin
      x_r[0] <= -(W'(1) <<< 30);
      z_r[0] <= in_ang - 32'h80000000;
    end else begin
      x_r[0] <= W'(1) <<< 30;
      z_r[0] <= in_ang;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (!z_r[i][31]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - tspu_pkg::atan_tab(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + tspu_pkg::atan_tab(i);
      end
    end
  end

  assign out_x = x_r[N];
  assign out_y = y_r[N];

endmodule

`default_nettype wire

[hw/rtl/three_step_phase_unwrap_pixel.sv]
// ----------------------------------------------------------------------------
// three_step_phase_unwrap_pixel: two-triplet phase average with gray unwrap
// ----------------------------------------------------------------------------
// channel  ports                         handshake
// input    in_first_*, in_second_*, ...  start high while busy low
// result   out_*                         out_valid strobe, one cycle
//
// one pixel enters every clock; busy is tied low
// the path runs through input products, 31 vectoring stages per triplet,
// 31 rotation stages, vector sum, 31 vectoring stages, rounding register
// synchronous reset clears only the valid bits; the data registers are not reset
// results cannot be held off, so nothing ever stalls
// ----------------------------------------------------------------------------
`default_nettype none

module three_step_phase_unwrap_pixel (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [7:0]          in_first_a,
  input  wire logic [7:0]          in_first_b,
  input  wire logic [7:0]          in_first_c,
  input  wire logic [7:0]          in_second_a,
  input  wire logic [7:0]          in_second_b,
  input  wire logic [7:0]          in_second_c,
  input  wire logic [6:0]          in_gray_bits,
  input  wire logic                in_frame_end,
  output logic                     out_valid,
  output logic signed [23:0]       out_unwrapped_phase,
  output logic signed [15:0]       out_average_phase,
  output logic [6:0]               out_fringe_order,
  output logic                     out_frame_end_out
);

  localparam int VW = tspu_pkg::VecW;
  localparam int RW = tspu_pkg::RotW;
  localparam int SW = tspu_pkg::SumW;
  localparam int PB = tspu_pkg::PhaseBits;
  localparam int GB = tspu_pkg::GrayBits;

  assign busy = 1'b0;

  // stage 0: triplet vectors and gray decode
  logic                 v0_r;
  logic signed [VW-1:0] x1_r, y1_r, x2_r, y2_r;
  tspu_pkg::side_t      side0_r;
  logic [GB-1:0]        order_nxt;

  always_comb begin
    order_nxt[GB-1] = in_gray_bits[GB-1];
    for (int i = GB - 2; i >= 0; i--) begin
      order_nxt[i] = order_nxt[i+1] ^ in_gray_bits[i];
    end
  end

  function automatic logic signed [VW-1:0] ydiff(input logic [7:0] a, input logic [7:0] c);
    logic signed [9:0]  d;
    logic signed [25:0] p;
    d = $signed({2'b00, a}) - $signed({2'b00, c});
    p = d * tspu_pkg::Sqrt3Q14;
    return VW'(p);
  endfunction

  function automatic logic signed [VW-1:0] xdiff(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
    logic signed [10:0] d;
    d = $signed({2'b00, b, 1'b0}) - $signed({3'b000, a}) - $signed({3'b000, c});
    return VW'(d) <<< 14;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    y1_r <= ydiff(in_first_a, in_first_c);
    x1_r <= xdiff(in_first_a, in_first_b, in_first_c);
    y2_r <= ydiff(in_second_a, in_second_c);
    x2_r <= xdiff(in_second_a, in_second_b, in_second_c);
    side0_r <= '{order: order_nxt, frame_end: in_frame_end};
  end

  logic            v1, v1b;
  tspu_pkg::ang_t  p1, p2;
  tspu_pkg::side_t side1, side1b;

  tspu_vec_cordic u_tri1 (
    .clk, .rst_n, .in_valid(v0_r), .in_x(x1_r), .in_y(y1_r), .in_side(side0_r),
    .out_valid(v1), .out_ang(p1), .out_side(side1)
  );
  tspu_vec_cordic u_tri2 (
    .clk, .rst_n, .in_valid(v0_r), .in_x(x2_r), .in_y(y2_r), .in_side(side0_r),
    .out_valid(v1b), .out_ang(p2), .out_side(side1b)
  );

  // rotation pipelines carry no control; delay valid and side alongside
  localparam int RD = tspu_pkg::CordicSteps + 1;
  logic            vr_r   [RD];
  tspu_pkg::side_t sider_r[RD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RD; i++) vr_r[i] <= 1'b0;
    end else begin
      vr_r[0] <= v1;
      for (int i = 1; i < RD; i++) vr_r[i] <= vr_r[i-1];
    end
    sider_r[0] <= side1;
    for (int i = 1; i < RD; i++) sider_r[i] <= sider_r[i-1];
  end

  logic signed [RW-1:0] rx1, ry1, rx2, ry2;

  tspu_rot_cordic u_rot1 (.clk, .in_ang(p1), .out_x(rx1), .out_y(ry1));
  tspu_rot_cordic u_rot2 (.clk, .in_ang(p2), .out_x(rx2), .out_y(ry2));

  // vector sum
  logic                 vs_r;
  logic signed [VW-1:0] sx_r, sy_r;
  tspu_pkg::side_t      sides_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= vr_r[RD-1];
    end
    sx_r    <= VW'(SW'(rx1) + SW'(rx2));
    sy_r    <= VW'(SW'(ry1) + SW'(ry2));
    sides_r <= sider_r[RD-1];
  end

  logic            va;
  tspu_pkg::ang_t  avg;
  tspu_pkg::side_t sidea;

  tspu_vec_cordic u_avg (
    .clk, .rst_n, .in_valid(vs_r), .in_x(sx_r), .in_y(sy_r), .in_side(sides_r),
    .out_valid(va), .out_ang(avg), .out_side(sidea)
  );

  // rounding and unwrap
  tspu_pkg::ang_t  rnd;
  logic [PB-1:0]   ph;
  logic            out_valid_r;
  logic signed [23:0] unw_r;
  logic signed [15:0] ph_r;
  logic [6:0]      ord_r;
  logic            fe_r;

  assign rnd = avg + (32'd1 << (31 - PB));
  assign ph  = rnd[31 -: PB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= va;
    end
    ph_r  <= $signed(ph);
    ord_r <= sidea.order;
    fe_r  <= sidea.frame_end;
    unw_r <= $signed({{(24-PB){ph[PB-1]}}, ph}) + $signed({1'b0, sidea.order, PB'(0)});
  end

  assign out_valid           = out_valid_r;
  assign out_unwrapped_phase = unw_r;
  assign out_average_phase   = ph_r;
  assign out_fringe_order    = ord_r;
  assign out_frame_end_out   = fe_r;

  a_twins: assert property (@(posedge clk) disable iff (!rst_n) v1 == v1b)
    else $error("triplet pipelines out of step");
  a_side: assert property (@(posedge clk) disable iff (!rst_n) v1 |-> side1 == side1b)
    else $error("triplet side data differs");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n) va |=> out_valid)
    else $error("result lost");

endmodule

`default_nettype wire
